[rtl/pddl_pkg.sv]
// ----------------------------------------------------------------------------
// pddl_pkg: shared types and constants for the PDDL tokenizer
// Token kinds, error codes, lexer modes, character codes, the result
// record and the queue entry passed between front and back.
// ----------------------------------------------------------------------------
package pddl_pkg;

  typedef enum logic [2:0] {
    KIND_LPAR = 3'd0,
    KIND_RPAR = 3'd1,
    KIND_KEY  = 3'd2,
    KIND_VAR  = 3'd3,
    KIND_NAME = 3'd4,
    KIND_NUM  = 3'd5,
    KIND_DASH = 3'd6,
    KIND_EOF  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_NO_KEY  = 2'd1,
    ERR_NO_VAR  = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_DASH,
    MODE_KEYSTART,
    MODE_VARSTART,
    MODE_KEYWORD,
    MODE_VARIABLE,
    MODE_NAME,
    MODE_NUMINT,
    MODE_NUMFRAC,
    MODE_HALT
  } mode_t;

  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Queue between front and back; a power of two.
  localparam int QDEPTH = 4;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  lexeme_byte;
    logic        byte_valid;
    logic        token_end;
    logic [15:0] start_line;
    logic [15:0] start_col;
    err_t        error;
    logic        last;
  } result_t;

  // One request's results: r0 always valid, r1 valid when two is set.
  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    two;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_wr_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return !is_space(c) && (c != CH_LPAR) && (c != CH_RPAR) && (c != CH_SEMI);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

[rtl/pddl_if.sv]
// ----------------------------------------------------------------------------
// pddl_if: channel interfaces of the PDDL tokenizer
// Valid/ready channels for input characters and for token results.
// ----------------------------------------------------------------------------
interface pddl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface pddl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  lexeme_byte;
  logic        byte_valid;
  logic        token_end;
  logic [15:0] start_line;
  logic [15:0] start_col;
  logic [1:0]  error;
  logic        last;

  modport source (output valid, output kind, output lexeme_byte, output byte_valid,
                  output token_end, output start_line, output start_col,
                  output error, output last, input ready);
  modport sink   (input valid, input kind, input lexeme_byte, input byte_valid,
                  input token_end, input start_line, input start_col,
                  input error, input last, output ready);
endinterface

[rtl/pddl_front.sv]
// ----------------------------------------------------------------------------
// pddl_front: character classifier and lexer state machine
// Takes one request per cycle unless the queue is full, updates mode and
// position counters and pushes its zero, one or two results into the queue.
// ----------------------------------------------------------------------------
module pddl_front
  import pddl_pkg::*;
#(
  parameter int POS_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_input,
  input  logic       q_full,
  output q_wr_t      q_wr
);

  localparam int PW = (POS_BITS > 16) ? POS_BITS : 16;

  mode_t               mode_r, mode_nxt;
  logic [POS_BITS-1:0] line_r, line_nxt, col_r, col_nxt;
  logic [POS_BITS-1:0] tok_line_r, tok_line_nxt, tok_col_r, tok_col_nxt;

  logic    accept;
  logic    pv, qv, use_sc, sc_v, sc_tok, s2v;
  result_t p, q, sc_res, s2, first, second;
  mode_t   sc_mode;
  logic [15:0] tl16, tc16, cl16, cc16;
  kind_t   wkind;

  function automatic logic [15:0] pos16(input logic [POS_BITS-1:0] v);
    logic [PW-1:0] e;
    e = PW'(v);
    return (e > PW'(16'hFFFF)) ? 16'hFFFF : e[15:0];
  endfunction

  function automatic result_t mk(input kind_t k, input logic [7:0] b, input logic bv,
                                 input logic te, input logic [15:0] ln,
                                 input logic [15:0] cl, input err_t er);
    result_t r;
    r.kind        = k;
    r.lexeme_byte = bv ? b : 8'h00;
    r.byte_valid  = bv;
    r.token_end   = te;
    r.start_line  = ln;
    r.start_col   = cl;
    r.error       = er;
    r.last        = 1'b0;
    return r;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign tl16 = pos16(tok_line_r);
  assign tc16 = pos16(tok_col_r);
  assign cl16 = pos16(line_r);
  assign cc16 = pos16(col_r);

  // A character seen with no token open: its result, if any, starts at
  // the current position.
  always_comb begin
    sc_mode = MODE_IDLE;
    sc_v    = 1'b0;
    sc_tok  = !is_space(in_ch);
    sc_res  = mk(KIND_NAME, in_ch, 1'b1, 1'b0, cl16, cc16, ERR_NONE);
    if (is_space(in_ch)) begin
      sc_mode = MODE_IDLE;
    end else if (in_ch == CH_SEMI) begin
      sc_mode = MODE_COMMENT;
    end else if (in_ch == CH_LPAR) begin
      sc_v   = 1'b1;
      sc_res = mk(KIND_LPAR, in_ch, 1'b1, 1'b1, cl16, cc16, ERR_NONE);
    end else if (in_ch == CH_RPAR) begin
      sc_v   = 1'b1;
      sc_res = mk(KIND_RPAR, in_ch, 1'b1, 1'b1, cl16, cc16, ERR_NONE);
    end else if (in_ch == CH_DASH) begin
      sc_mode = MODE_DASH;
    end else if (is_digit(in_ch)) begin
      sc_mode = MODE_NUMINT;
      sc_v    = 1'b1;
      sc_res  = mk(KIND_NUM, in_ch, 1'b1, 1'b0, cl16, cc16, ERR_NONE);
    end else if (in_ch == CH_COLON) begin
      sc_mode = MODE_KEYSTART;
    end else if (in_ch == CH_QUEST) begin
      sc_mode = MODE_VARSTART;
    end else begin
      sc_mode = MODE_NAME;
      sc_v    = 1'b1;
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    line_nxt     = line_r;
    col_nxt      = col_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    pv     = 1'b0;
    qv     = 1'b0;
    use_sc = 1'b0;
    p      = mk(KIND_EOF, 8'h00, 1'b0, 1'b1, tl16, tc16, ERR_NONE);
    q      = mk(KIND_NAME, in_ch, 1'b1, 1'b0, tl16, tc16, ERR_NONE);
    wkind  = (mode_r == MODE_KEYWORD) ? KIND_KEY :
             (mode_r == MODE_VARIABLE) ? KIND_VAR : KIND_NAME;

    if (in_end_of_input) begin
      // Close any open token, then EOF at the current position.
      qv = 1'b1;
      q  = mk(KIND_EOF, 8'h00, 1'b0, 1'b1, cl16, cc16, ERR_NONE);
      unique case (mode_r) inside
        MODE_DASH: begin
          pv = 1'b1;
          p  = mk(KIND_DASH, CH_DASH, 1'b1, 1'b1, tl16, tc16, ERR_NONE);
        end
        MODE_KEYSTART: begin
          pv = 1'b1;
          p  = mk(KIND_KEY, 8'h00, 1'b0, 1'b1, tl16, tc16, ERR_NO_KEY);
        end
        MODE_VARSTART: begin
          pv = 1'b1;
          p  = mk(KIND_VAR, 8'h00, 1'b0, 1'b1, tl16, tc16, ERR_NO_VAR);
        end
        MODE_KEYWORD, MODE_VARIABLE, MODE_NAME: begin
          pv = 1'b1;
          p  = mk(wkind, 8'h00, 1'b0, 1'b1, tl16, tc16, ERR_NONE);
        end
        MODE_NUMINT, MODE_NUMFRAC: begin
          pv = 1'b1;
          p  = mk(KIND_NUM, 8'h00, 1'b0, 1'b1, tl16, tc16, ERR_NONE);
        end
        default: begin
          pv = 1'b0;
        end
      endcase
      mode_nxt     = MODE_IDLE;
      line_nxt     = POS_BITS'(1);
      col_nxt      = POS_BITS'(1);
      tok_line_nxt = POS_BITS'(1);
      tok_col_nxt  = POS_BITS'(1);
    end else begin
      unique case (mode_r) inside
        MODE_COMMENT: begin
          if (in_ch == CH_NL) mode_nxt = MODE_IDLE;
        end
        MODE_HALT: begin
          mode_nxt = MODE_HALT;
        end
        MODE_DASH: begin
          pv = 1'b1;
          if (is_name_char(in_ch)) begin
            mode_nxt = MODE_NAME;
            p  = mk(KIND_NAME, CH_DASH, 1'b1, 1'b0, tl16, tc16, ERR_NONE);
            qv = 1'b1;
          end else begin
            p      = mk(KIND_DASH, CH_DASH, 1'b1, 1'b1, tl16, tc16, ERR_NONE);
            use_sc = 1'b1;
          end
        end
        MODE_KEYSTART, MODE_VARSTART: begin
          pv = 1'b1;
          if (is_name_char(in_ch)) begin
            mode_nxt = (mode_r == MODE_KEYSTART) ? MODE_KEYWORD : MODE_VARIABLE;
            p = mk((mode_r == MODE_KEYSTART) ? KIND_KEY : KIND_VAR, in_ch, 1'b1, 1'b0,
                   tl16, tc16, ERR_NONE);
          end else begin
            mode_nxt = MODE_HALT;
            p = mk((mode_r == MODE_KEYSTART) ? KIND_KEY : KIND_VAR, 8'h00, 1'b0, 1'b1,
                   tl16, tc16, (mode_r == MODE_KEYSTART) ? ERR_NO_KEY : ERR_NO_VAR);
          end
        end
        MODE_KEYWORD, MODE_VARIABLE, MODE_NAME: begin
          pv = 1'b1;
          if (is_name_char(in_ch)) begin
            p = mk(wkind, in_ch, 1'b1, 1'b0, tl16, tc16, ERR_NONE);
          end else begin
            p      = mk(wkind, 8'h00, 1'b0, 1'b1, tl16, tc16, ERR_NONE);
            use_sc = 1'b1;
          end
        end
        MODE_NUMINT, MODE_NUMFRAC: begin
          pv = 1'b1;
          if (is_digit(in_ch)) begin
            p = mk(KIND_NUM, in_ch, 1'b1, 1'b0, tl16, tc16, ERR_NONE);
          end else if ((in_ch == CH_DOT) && (mode_r == MODE_NUMINT)) begin
            mode_nxt = MODE_NUMFRAC;
            p = mk(KIND_NUM, in_ch, 1'b1, 1'b0, tl16, tc16, ERR_NONE);
          end else begin
            p      = mk(KIND_NUM, 8'h00, 1'b0, 1'b1, tl16, tc16, ERR_NONE);
            use_sc = 1'b1;
          end
        end
        default: begin
          use_sc = 1'b1;
        end
      endcase

      if (use_sc) begin
        mode_nxt = sc_mode;
        if (sc_tok) begin
          tok_line_nxt = line_r;
          tok_col_nxt  = col_r;
        end
      end

      // Position counters saturate at all ones.
      if (in_ch == CH_NL) begin
        if (!(&line_r)) line_nxt = line_r + POS_BITS'(1);
        col_nxt = POS_BITS'(1);
      end else if (!(&col_r)) begin
        col_nxt = col_r + POS_BITS'(1);
      end
    end

    if (use_sc) begin
      s2  = sc_res;
      s2v = sc_v;
    end else begin
      s2  = q;
      s2v = qv;
    end
    first  = pv ? p : s2;
    second = s2;
    if (pv && s2v) second.last = 1'b1;
    else           first.last  = 1'b1;

    q_wr.push      = accept && (pv || s2v);
    q_wr.entry.r0  = first;
    q_wr.entry.r1  = second;
    q_wr.entry.two = pv && s2v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      line_r     <= POS_BITS'(1);
      col_r      <= POS_BITS'(1);
      tok_line_r <= POS_BITS'(1);
      tok_col_r  <= POS_BITS'(1);
    end else if (accept) begin
      mode_r     <= mode_nxt;
      line_r     <= line_nxt;
      col_r      <= col_nxt;
      tok_line_r <= tok_line_nxt;
      tok_col_r  <= tok_col_nxt;
    end
  end

endmodule

[rtl/pddl_queue.sv]
// ----------------------------------------------------------------------------
// pddl_queue: short request queue between front and back
// Holds up to QDEPTH entries of one or two results each.
// ----------------------------------------------------------------------------
module pddl_queue
  import pddl_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  q_wr_t  q_wr,
  output logic   q_full,
  output logic   rd_valid,
  output entry_t rd_entry,
  input  logic   rd_pop
);

  localparam int QA = $clog2(QDEPTH);

  entry_t        mem_r [QDEPTH];
  logic [QA-1:0] wr_ptr_r, rd_ptr_r;
  logic [QA:0]   count_r, count_nxt;
  logic          do_pop;

  assign q_full   = (count_r == (QA+1)'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_entry = mem_r[rd_ptr_r];
  assign do_pop   = rd_pop && rd_valid;

  always_comb begin
    count_nxt = count_r;
    if (q_wr.push && !do_pop)      count_nxt = count_r + (QA+1)'(1);
    else if (!q_wr.push && do_pop) count_nxt = count_r - (QA+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) mem_r[wr_ptr_r] <= q_wr.entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_wr.push) wr_ptr_r <= wr_ptr_r + QA'(1);
      if (do_pop)    rd_ptr_r <= rd_ptr_r + QA'(1);
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/pddl_back.sv]
// ----------------------------------------------------------------------------
// pddl_back: result sequencer and output register
// Drains queue entries into the output register at one result per unstalled cycle.
// ----------------------------------------------------------------------------
module pddl_back
  import pddl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    rd_valid,
  input  entry_t  rd_entry,
  output logic    rd_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    out_valid_r, sel_r, load;
  result_t out_res_r;

  assign load   = rd_valid && (!out_valid_r || out_ready);
  assign rd_pop = load && (!rd_entry.two || sel_r);

  always_ff @(posedge clk) begin
    if (load) out_res_r <= sel_r ? rd_entry.r1 : rd_entry.r0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sel_r       <= rd_entry.two && !sel_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

[rtl/pddl_tokenizer.sv]
// ----------------------------------------------------------------------------
// pddl_tokenizer: streaming PDDL lexer, one character per request
// Skips whitespace and semicolon comments, and emits parentheses, keywords,
// variables, names, numbers, lone dashes and an end-of-file token as a
// stream of lexeme bytes with token boundaries and start positions.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Payload                                   | Per request
//   --------+-----------+-------------------------------------------+------------
//   in_if   | sink      | ch, end_of_input                          | 1 character
//   out_if  | source    | kind, lexeme_byte, byte_valid, token_end, | 0 to 2
//           |           | start_line, start_col, error, last        | results
//
// A character is lexed in the cycle it is accepted and its results enter a
// four-entry queue; the back end sends one result per unstalled cycle from a
// single output register. Requests that cause zero or one result flow at one
// per cycle; the back end splits a two-result request into two outputs, so
// the sustained rate is one result per cycle. Reset (rst_n low, synchronous)
// returns the lexer to idle at line 1, column 1 and empties the queue. A
// stall on the output fills the queue, after which in_if.ready drops.
// ----------------------------------------------------------------------------
module pddl_tokenizer
  import pddl_pkg::*;
#(
  parameter int POS_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  pddl_in_if.sink           in_if,
  pddl_out_if.source        out_if
);

  q_wr_t   q_wr;
  logic    q_full;
  logic    rd_valid, rd_pop;
  entry_t  rd_entry;
  result_t out_res;

  // The front end owns the lexer mode and the line and column counters.
  pddl_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_if.valid),
    .in_ready        (in_if.ready),
    .in_ch           (in_if.ch),
    .in_end_of_input (in_if.end_of_input),
    .q_full          (q_full),
    .q_wr            (q_wr)
  );

  // The queue decouples lexing from an output that may stall.
  pddl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_wr     (q_wr),
    .q_full   (q_full),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry),
    .rd_pop   (rd_pop)
  );

  // The back end splits two-result entries and registers each result.
  pddl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (rd_valid),
    .rd_entry  (rd_entry),
    .rd_pop    (rd_pop),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (out_res)
  );

  assign out_if.kind        = out_res.kind;
  assign out_if.lexeme_byte = out_res.lexeme_byte;
  assign out_if.byte_valid  = out_res.byte_valid;
  assign out_if.token_end   = out_res.token_end;
  assign out_if.start_line  = out_res.start_line;
  assign out_if.start_col   = out_res.start_col;
  assign out_if.error       = out_res.error;
  assign out_if.last        = out_res.last;

endmodule

[rtl/pddl_checker.sv]
// ----------------------------------------------------------------------------
// pddl_checker: port-level checks for the PDDL tokenizer
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module pddl_checker
  import pddl_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_lexeme_byte,
  input logic        out_byte_valid,
  input logic        out_token_end,
  input logic [1:0]  out_error,
  input logic        out_last
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_lexeme_byte)
                                && $stable(out_last) && $stable(out_error))
    else $error("result changed while stalled");

  // Nothing is offered in the cycle after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // An error result carries no byte and closes its token. At end of input it
  // is followed by the end-of-file token, so it need not end its request.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error != ERR_NONE) |-> out_token_end && !out_byte_valid)
    else $error("malformed error result");

  // The end-of-file token is always the final result of its request.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_EOF) |-> out_last && out_token_end)
    else $error("end-of-file token not final");

endmodule

bind pddl_tokenizer pddl_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_kind        (out_if.kind),
  .out_lexeme_byte (out_if.lexeme_byte),
  .out_byte_valid  (out_if.byte_valid),
  .out_token_end   (out_if.token_end),
  .out_error       (out_if.error),
  .out_last        (out_if.last)
);

[bench/token_checker.sv]
// ----------------------------------------------------------------------------
// token_checker: token prediction and result comparison for pddl_tokenizer
// Watches both channels, lexes each accepted request with its own copy of
// the tokenizer state, and compares every result with the oldest expected one.
// ----------------------------------------------------------------------------
module token_checker
  import pddl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pddl_in_if   in_mon,
  pddl_out_if  out_mon,
  output int   mismatches,
  output int   outstanding
);

  localparam logic [15:0] POS_TOP = 16'hFFFF;

  result_t     tok_expect[$];
  mode_t       lex_mode = MODE_IDLE;
  logic [15:0] cur_line = 16'd1;
  logic [15:0] cur_col = 16'd1;
  logic [15:0] tok_line = 16'd1;
  logic [15:0] tok_col = 16'd1;
  result_t     held;
  logic        held_ok = 1'b0;
  int          bad = 0;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return !is_blank(c) && (c != CH_LPAR) && (c != CH_RPAR) && (c != CH_SEMI);
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic kind_t word_kind(input mode_t m);
    if (m == MODE_KEYWORD) return KIND_KEY;
    if (m == MODE_VARIABLE) return KIND_VAR;
    return KIND_NAME;
  endfunction

  task automatic reset_lexer();
    lex_mode = MODE_IDLE;
    cur_line = 16'd1;
    cur_col  = 16'd1;
    tok_line = 16'd1;
    tok_col  = 16'd1;
  endtask

  // Appends one expected result behind the ones already waiting.
  task automatic queue_result(input result_t r);
    tok_expect.insert(tok_expect.size(), r);
  endtask

  // The newest result of a request is held back so that it can carry the
  // last flag once the request is fully lexed.
  task automatic put(input kind_t k, input logic [7:0] b, input logic bv, input logic te,
                     input logic [15:0] ln, input logic [15:0] cl, input err_t e);
    if (held_ok) queue_result(held);
    held.kind        = k;
    held.lexeme_byte = bv ? b : 8'h00;
    held.byte_valid  = bv;
    held.token_end   = te;
    held.start_line  = ln;
    held.start_col   = cl;
    held.error       = e;
    held.last        = 1'b0;
    held_ok          = 1'b1;
  endtask

  task automatic put_byte(input kind_t k, input logic [7:0] c);
    put(k, c, 1'b1, 1'b0, tok_line, tok_col, ERR_NONE);
  endtask

  task automatic put_close(input kind_t k);
    put(k, 8'h00, 1'b0, 1'b1, tok_line, tok_col, ERR_NONE);
  endtask

  task automatic open_token(input logic [7:0] c);
    lex_mode = MODE_IDLE;
    if (!is_blank(c)) begin
      tok_line = cur_line;
      tok_col  = cur_col;
      if (c == CH_SEMI) lex_mode = MODE_COMMENT;
      else if (c == CH_LPAR) put(KIND_LPAR, c, 1'b1, 1'b1, tok_line, tok_col, ERR_NONE);
      else if (c == CH_RPAR) put(KIND_RPAR, c, 1'b1, 1'b1, tok_line, tok_col, ERR_NONE);
      else if (c == CH_DASH) lex_mode = MODE_DASH;
      else if (is_numeral(c)) begin
        lex_mode = MODE_NUMINT;
        put_byte(KIND_NUM, c);
      end else if (c == CH_COLON) lex_mode = MODE_KEYSTART;
      else if (c == CH_QUEST) lex_mode = MODE_VARSTART;
      else begin
        lex_mode = MODE_NAME;
        put_byte(KIND_NAME, c);
      end
    end
  endtask

  task automatic lex_char(input logic [7:0] c);
    kind_t pk;
    err_t  pe;
    mode_t pm;
    case (lex_mode)
      MODE_COMMENT: if (c == CH_NL) lex_mode = MODE_IDLE;
      MODE_HALT: ;
      MODE_DASH: begin
        if (is_word_char(c)) begin
          lex_mode = MODE_NAME;
          put_byte(KIND_NAME, CH_DASH);
          put_byte(KIND_NAME, c);
        end else begin
          put(KIND_DASH, CH_DASH, 1'b1, 1'b1, tok_line, tok_col, ERR_NONE);
          open_token(c);
        end
      end
      MODE_KEYSTART, MODE_VARSTART: begin
        if (lex_mode == MODE_KEYSTART) begin
          pk = KIND_KEY;
          pe = ERR_NO_KEY;
          pm = MODE_KEYWORD;
        end else begin
          pk = KIND_VAR;
          pe = ERR_NO_VAR;
          pm = MODE_VARIABLE;
        end
        if (is_word_char(c)) begin
          lex_mode = pm;
          put_byte(pk, c);
        end else begin
          put(pk, 8'h00, 1'b0, 1'b1, tok_line, tok_col, pe);
          lex_mode = MODE_HALT;
        end
      end
      MODE_KEYWORD, MODE_VARIABLE, MODE_NAME: begin
        if (is_word_char(c)) put_byte(word_kind(lex_mode), c);
        else begin
          put_close(word_kind(lex_mode));
          open_token(c);
        end
      end
      MODE_NUMINT, MODE_NUMFRAC: begin
        if (is_numeral(c)) put_byte(KIND_NUM, c);
        else if ((c == CH_DOT) && (lex_mode == MODE_NUMINT)) begin
          lex_mode = MODE_NUMFRAC;
          put_byte(KIND_NUM, c);
        end else begin
          put_close(KIND_NUM);
          open_token(c);
        end
      end
      default: open_token(c);
    endcase
    if (c == CH_NL) begin
      if (cur_line != POS_TOP) cur_line++;
      cur_col = 16'd1;
    end else if (cur_col != POS_TOP) begin
      cur_col++;
    end
  endtask

  task automatic lex_end();
    case (lex_mode)
      MODE_DASH:     put(KIND_DASH, CH_DASH, 1'b1, 1'b1, tok_line, tok_col, ERR_NONE);
      MODE_KEYSTART: put(KIND_KEY, 8'h00, 1'b0, 1'b1, tok_line, tok_col, ERR_NO_KEY);
      MODE_VARSTART: put(KIND_VAR, 8'h00, 1'b0, 1'b1, tok_line, tok_col, ERR_NO_VAR);
      MODE_KEYWORD, MODE_VARIABLE, MODE_NAME: put_close(word_kind(lex_mode));
      MODE_NUMINT, MODE_NUMFRAC: put_close(KIND_NUM);
      default: ;
    endcase
    put(KIND_EOF, 8'h00, 1'b0, 1'b1, cur_line, cur_col, ERR_NONE);
    reset_lexer();
  endtask

  task automatic predict_tokens(input logic [7:0] c, input logic eoi);
    held_ok = 1'b0;
    if (eoi) lex_end();
    else lex_char(c);
    if (held_ok) begin
      held.last = 1'b1;
      queue_result(held);
      held_ok = 1'b0;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (!rst_n) begin
      reset_lexer();
      tok_expect.delete();
      held_ok = 1'b0;
    end else begin
      if (in_mon.valid && in_mon.ready) predict_tokens(in_mon.ch, in_mon.end_of_input);
      if (out_mon.valid && out_mon.ready) begin
        got.kind        = kind_t'(out_mon.kind);
        got.lexeme_byte = out_mon.lexeme_byte;
        got.byte_valid  = out_mon.byte_valid;
        got.token_end   = out_mon.token_end;
        got.start_line  = out_mon.start_line;
        got.start_col   = out_mon.start_col;
        got.error       = err_t'(out_mon.error);
        got.last        = out_mon.last;
        if (tok_expect.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("tb: unexpected result kind=%0d byte=%02h line=%0d col=%0d",
                     got.kind, got.lexeme_byte, got.start_line, got.start_col);
        end else begin
          want = tok_expect.pop_front();
          if (got.kind !== want.kind || got.lexeme_byte !== want.lexeme_byte ||
              got.byte_valid !== want.byte_valid || got.token_end !== want.token_end ||
              got.start_line !== want.start_line || got.start_col !== want.start_col ||
              got.error !== want.error || got.last !== want.last) begin
            bad++;
            if (bad <= 10) begin
              $display("tb: mismatch exp kind=%0d byte=%02h bv=%0d te=%0d line=%0d",
                       want.kind, want.lexeme_byte, want.byte_valid, want.token_end,
                       want.start_line, " col=%0d err=%0d last=%0d",
                       want.start_col, want.error, want.last);
              $display("tb: mismatch got kind=%0d byte=%02h bv=%0d te=%0d line=%0d",
                       got.kind, got.lexeme_byte, got.byte_valid, got.token_end,
                       got.start_line, " col=%0d err=%0d last=%0d",
                       got.start_col, got.error, got.last);
            end
          end
        end
      end
    end
    mismatches  <= bad;
    outstanding <= tok_expect.size();
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the PDDL tokenizer
// Feeds a directed opening and about six hundred random requests of
// PDDL-like text with noise, with random idle bursts on both channels and a
// final stretch without idling; token_checker does the checking.
// ----------------------------------------------------------------------------
module testbench
  import pddl_pkg::*;
;

  // Number of counted random requests before the random phase stops.
  localparam int ITEM_GOAL = 600;
  // Counted requests at the end of the random phase sent without idling.
  localparam int TAIL_ITEMS = 100;
  // Hard stop; the slowest correct run stays well below this.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Cycles allowed after the last expected result for stray output.
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pddl_in_if  in_ch ();
  pddl_out_if out_ch ();

  int   mismatches;
  int   outstanding;
  int   items_sent = 0;
  int   cycles = 0;
  int   stall_left = 0;
  // When quiet_tail is set neither side idles any more.
  logic quiet_tail = 1'b0;
  // These flags switch idling on and off in stretches, so the run also
  // contains long runs of back-to-back traffic.
  logic source_bursty = 1'b1;
  logic sink_bursty = 1'b1;

  pddl_tokenizer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  token_checker tok_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result sink. Ready drops in bursts while bursty;
  // stalls are allowed to land on any result, including the second result
  // of a two-result request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet_tail && sink_bursty && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      if ($urandom_range(0, 199) == 0) sink_bursty = !sink_bursty;
    end
  end

  // Drives one request and returns at the edge where it is accepted. A new
  // request is driven in that same step, so valid stays high across
  // back-to-back requests with a single assignment per step. Requests that
  // the tokenizer ignores while halted are sent uncounted.
  task automatic send_item(input logic [7:0] c, input logic eoi, input logic counted);
    if (!quiet_tail && source_bursty && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.ch           <= c;
    in_ch.end_of_input <= eoi;
    do @(posedge clk); while (!in_ch.ready);
    if (counted) items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(c, 1'b0, 1'b1);
  endtask

  // The character lane carries random junk with an end-of-input request,
  // since the tokenizer must ignore it.
  task automatic send_eoi();
    send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] pick_gap();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_NL;
      3:       return CH_CR;
      4:       return 8'h0B;
      default: return 8'h0C;
    endcase
  endfunction

  // Mostly ordinary identifier characters, now and then the odd bytes that
  // are still legal inside a word: prefixes, dots, control and high bytes.
  function automatic logic [7:0] pick_word_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'(8'h61 + $urandom_range(0, 25));
      4:          return 8'(8'h41 + $urandom_range(0, 25));
      5:          return 8'(CH_ZERO + $urandom_range(0, 9));
      6:          return CH_DASH;
      7: begin
        case ($urandom_range(0, 2))
          0:       return CH_COLON;
          1:       return CH_QUEST;
          default: return CH_DOT;
        endcase
      end
      8:          return 8'($urandom_range(0, 8));
      default:    return 8'($urandom_range(128, 255));
    endcase
  endfunction

  task automatic send_word(input int n);
    repeat (n) send_char(pick_word_char());
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_char(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  // Words are usually followed by whitespace, as in real source text, but
  // sometimes run straight into the next token.
  task automatic tail_gap();
    if ($urandom_range(0, 9) < 7) send_char(pick_gap());
  endtask

  // One random token of PDDL-like text, or a piece of noise.
  task automatic send_random_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      send_char(CH_LPAR);
    end else if (r < 24) begin
      send_char(CH_RPAR);
    end else if (r < 34) begin
      send_char(CH_COLON);
      send_word($urandom_range(1, 6));
      tail_gap();
    end else if (r < 44) begin
      send_char(CH_QUEST);
      send_word($urandom_range(1, 6));
      tail_gap();
    end else if (r < 58) begin
      send_char(8'(8'h61 + $urandom_range(0, 25)));
      send_word($urandom_range(0, 7));
      tail_gap();
    end else if (r < 68) begin
      // Integer, optional fraction, and sometimes a stray dot that, after the
      // fraction's dot, closes the number and starts a name.
      send_digits($urandom_range(1, 4));
      if ($urandom_range(0, 1) == 1) begin
        send_char(CH_DOT);
        send_digits($urandom_range(0, 3));
      end
      if ($urandom_range(0, 5) == 0) send_char(CH_DOT);
      tail_gap();
    end else if (r < 73) begin
      send_char(CH_DASH);
      if ($urandom_range(0, 1) == 1) send_char(pick_gap());
    end else if (r < 78) begin
      send_char(CH_SEMI);
      repeat ($urandom_range(0, 8)) send_char(8'($urandom_range(0, 255)));
      send_char(CH_NL);
    end else if (r < 88) begin
      repeat ($urandom_range(1, 3)) send_char(pick_gap());
    end else if (r < 95) begin
      send_char(8'($urandom_range(0, 255)));
    end else if (r < 97) begin
      // Keyword or variable prefix, often cut short by whitespace or ')': the
      // tokenizer then halts, ignores what follows, and only end of input brings it back.
      send_char(($urandom_range(0, 1) == 1) ? CH_COLON : CH_QUEST);
      case ($urandom_range(0, 2))
        0:       send_char(pick_gap());
        1:       send_char(CH_RPAR);
        default: ;
      endcase
      repeat ($urandom_range(0, 4)) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_eoi();
    end else begin
      send_eoi();
    end
  endtask

  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.ch           <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. Parenthesis, keyword, variable, a dash that turns
    // into a name ending in byte 0xFF, a lone dash held until '(' decides
    // it, a number cut short by its second dot, a comment to end of line,
    // and a name made of byte 0x00 closed by end of input.
    send_text("(:k ?v\t-");
    send_char(8'hFF);
    send_text(" -(1.2.3;c\n)");
    send_char(8'h00);
    send_eoi();
    // Keyword with no name: error, then a halted character, then restart.
    send_text(":)z");
    send_eoi();
    // Variable prefix and dash both left open at end of input.
    send_text("?");
    send_eoi();
    send_text("-");
    send_eoi();

    // Random phase; its last stretch runs without idling on either side.
    items_sent = 0;
    while (items_sent < ITEM_GOAL) begin
      if (items_sent >= ITEM_GOAL - TAIL_ITEMS) quiet_tail = 1'b1;
      send_random_token();
      if ($urandom_range(0, 29) == 0) source_bursty = !source_bursty;
    end
    send_eoi();

    // Drop valid, wait for the checker to see the last request, then drain.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
